// ----- hdl/dng_pkg.sv -----
// Shared types, constants and helpers for the digital net generator.
package dng_pkg;

  localparam int MAX_DIMS    = 16;
  localparam int MAX_COLUMNS = 32;
  localparam int WORD_BITS   = 64;

  localparam int DIM_W  = $clog2(MAX_DIMS);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ADDR_W = DIM_W + COL_W;
  localparam int CFG_W  = 7;

  typedef enum logic [1:0] {
    OP_LOAD_MAT   = 2'd0,
    OP_LOAD_SHIFT = 2'd1,
    OP_START      = 2'd2,
    OP_ADVANCE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BOUNDS  = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NO_RUN  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_DIMS_USED     = 3'd0,
    CFG_COLUMNS_USED  = 3'd1,
    CFG_FRACTION_BITS = 3'd2,
    CFG_GRAY_ORDER    = 3'd3,
    CFG_SHIFT_ENABLE  = 3'd4
  } cfg_idx_t;

  // Control from the sequencer to the coordinate unit.
  typedef struct packed {
    logic             clear;
    logic             xor_en;
    logic [DIM_W-1:0] rd_dim;
    logic             shift_we;
    logic [DIM_W-1:0] shift_dim;
  } coord_ctl_t;

  function automatic logic [WORD_BITS-1:0] frac_mask(input logic [6:0] fb);
    logic [WORD_BITS-1:0] m;
    if (fb >= 7'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << fb) - WORD_BITS'(1);
    end
    return m;
  endfunction

endpackage

// ----- hdl/dng_in_if.sv -----
// Input channel of the digital net generator.
interface dng_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  dim;
  logic [4:0]  column;
  logic [63:0] word;
  logic [31:0] start_index;
  logic [32:0] sample_count;

  modport source (output valid, op, dim, column, word, start_index, sample_count,
                  input ready);
  modport sink   (input valid, op, dim, column, word, start_index, sample_count,
                  output ready);
endinterface

// ----- hdl/dng_out_if.sv -----
// Result channel of the digital net generator.
interface dng_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] position;
  logic [3:0]  out_dim;
  logic [63:0] point_word;
  logic [63:0] shifted_word;
  logic        last;

  modport source (output valid, status, position, out_dim, point_word, shifted_word, last,
                  input ready);
  modport sink   (input valid, status, position, out_dim, point_word, shifted_word, last,
                  output ready);
endinterface

// ----- hdl/dng_mat_mem.sv -----
// Generating matrix store: one write port, one registered read port.
module dng_mat_mem
  import dng_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem_r [MAX_DIMS*MAX_COLUMNS];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/dng_coord.sv -----
// Coordinate accumulators, digital shift table and output word formatting.
module dng_coord
  import dng_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  coord_ctl_t           ctl,
  input  logic [WORD_BITS-1:0] shift_wdata,
  input  logic [WORD_BITS-1:0] xor_data,
  input  logic [WORD_BITS-1:0] fmask,
  input  logic                 shift_en,
  output logic [WORD_BITS-1:0] point_word,
  output logic [WORD_BITS-1:0] shifted_word
);

  logic [WORD_BITS-1:0] acc_r   [MAX_DIMS];
  logic [WORD_BITS-1:0] shift_r [MAX_DIMS];
  logic [WORD_BITS-1:0] acc_rd;

  assign acc_rd = acc_r[ctl.rd_dim];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        acc_r[j] <= '0;
      end
    end else if (ctl.xor_en) begin
      acc_r[ctl.rd_dim] <= acc_rd ^ xor_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_we) begin
      shift_r[ctl.shift_dim] <= shift_wdata;
    end
  end

  assign point_word   = acc_rd & fmask;
  assign shifted_word = shift_en ? ((acc_rd ^ shift_r[ctl.rd_dim]) & fmask) : '0;

endmodule

// ----- hdl/digital_net_base2_generator_top.sv -----
// Digital net generator: sequencer, configuration, matrix store and result register.
// A start checks its bounds, then reads each column in use of all MAX_DIMS dimensions
// before its dims_used result beats; an advance scans the new index for its lowest set
// bit, then reads that column of every dimension, then gives dims_used beats. One XOR
// unit is fed by the single matrix read port; one item is in work at a time.
// Synchronous reset clears control state and loads the register defaults; tables are undefined.
module digital_net_base2_generator_top
  import dng_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  dng_in_if.sink           in_ch,
  dng_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_BUILD = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_ERR   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [4:0] dims_used_r;
  logic [5:0] columns_used_r;
  logic [6:0] fraction_bits_r;
  logic       gray_order_r;
  logic       shift_enable_r;

  // run state
  logic [31:0] first_r,  first_nxt;
  logic [32:0] cur_r,    cur_nxt;
  logic [32:0] endidx_r, endidx_nxt;
  logic        run_r,    run_nxt;
  logic [31:0] start_r,  start_nxt;
  logic [33:0] end_r,    end_nxt;
  logic [31:0] g_r,      g_nxt;

  // scan and build sequencing
  logic [31:0]      scan_sr_r, scan_sr_nxt;
  logic [5:0]       scan_k_r,  scan_k_nxt;
  logic [DIM_W-1:0] bld_j_r,   bld_j_nxt;
  logic [COL_W-1:0] bld_m_r,   bld_m_nxt;
  logic [COL_W-1:0] bld_lo_r,  bld_lo_nxt;
  logic [COL_W-1:0] bld_hi_r,  bld_hi_nxt;
  logic             bld_all_r, bld_all_nxt;
  logic             tag_v_r,   tag_sel_r;
  logic [DIM_W-1:0] tag_j_r;
  logic [DIM_W-1:0] emit_j_r,  emit_j_nxt;
  logic [1:0]       err_r,     err_nxt;

  // result register
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [31:0]          out_position_r;
  logic [DIM_W-1:0]     out_dim_r;
  logic [WORD_BITS-1:0] out_point_r;
  logic [WORD_BITS-1:0] out_shifted_r;
  logic                 out_last_r;

  logic       load_pt, load_err, out_free, in_acc, clear_acc;
  logic [4:0] nd;
  logic [5:0] cols;
  logic [32:0] slot;
  logic [33:0] start_p1;
  logic        err1, err2;
  logic [WORD_BITS-1:0] mem_rdata, point_word, shifted_word;
  coord_ctl_t  cctl;

  assign nd       = (dims_used_r > 5'(MAX_DIMS)) ? 5'(MAX_DIMS) : dims_used_r;
  assign cols     = (columns_used_r > 6'(MAX_COLUMNS)) ? 6'(MAX_COLUMNS) : columns_used_r;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign slot     = gray_order_r ? cur_r : (cur_r ^ (cur_r >> 1));
  assign start_p1 = {2'b00, start_r} + 34'd1;

  assign err1 = !gray_order_r &&
                (((start_r != '0) && ((start_r & (start_r - 32'd1)) != '0)) ||
                 ((end_r & (end_r - 34'd1)) != '0));
  assign err2 = end_r > (34'd1 << cols);

  assign in_ch.ready = (state_r == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_used_r     <= 5'd1;
      columns_used_r  <= 6'd32;
      fraction_bits_r <= 7'd32;
      gray_order_r    <= 1'b1;
      shift_enable_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DIMS_USED:     dims_used_r     <= cfg_data[4:0];
        CFG_COLUMNS_USED:  columns_used_r  <= cfg_data[5:0];
        CFG_FRACTION_BITS: fraction_bits_r <= cfg_data[6:0];
        CFG_GRAY_ORDER:    gray_order_r    <= cfg_data[0];
        CFG_SHIFT_ENABLE:  shift_enable_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    first_nxt   = first_r;
    cur_nxt     = cur_r;
    endidx_nxt  = endidx_r;
    run_nxt     = run_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    g_nxt       = g_r;
    scan_sr_nxt = scan_sr_r;
    scan_k_nxt  = scan_k_r;
    bld_j_nxt   = bld_j_r;
    bld_m_nxt   = bld_m_r;
    bld_lo_nxt  = bld_lo_r;
    bld_hi_nxt  = bld_hi_r;
    bld_all_nxt = bld_all_r;
    emit_j_nxt  = emit_j_r;
    err_nxt     = err_r;
    load_pt     = 1'b0;
    load_err    = 1'b0;
    clear_acc   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_ch.op))
            OP_START: begin
              run_nxt   = 1'b0;
              start_nxt = in_ch.start_index;
              end_nxt   = {2'b00, in_ch.start_index} + {1'b0, in_ch.sample_count};
              if (in_ch.sample_count != '0 && nd != '0) begin
                state_nxt = S_CHECK;
              end
            end
            OP_ADVANCE: begin
              if (!run_r) begin
                err_nxt   = ST_NO_RUN;
                state_nxt = S_ERR;
              end else begin
                cur_nxt     = cur_r + 33'd1;
                run_nxt     = ({1'b0, cur_nxt} + 34'd1) < {1'b0, endidx_r};
                scan_sr_nxt = cur_nxt[31:0];
                scan_k_nxt  = '0;
                state_nxt   = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_CHECK: begin
        if (err1) begin
          err_nxt   = ST_BOUNDS;
          state_nxt = S_ERR;
        end else if (err2) begin
          err_nxt   = ST_RANGE;
          state_nxt = S_ERR;
        end else begin
          clear_acc   = 1'b1;
          first_nxt   = start_r;
          cur_nxt     = {1'b0, start_r};
          endidx_nxt  = end_r[32:0];
          run_nxt     = start_p1 < end_r;
          g_nxt       = start_r ^ (start_r >> 1);
          bld_j_nxt   = '0;
          bld_m_nxt   = '0;
          bld_lo_nxt  = '0;
          bld_hi_nxt  = COL_W'(cols - 6'd1);
          bld_all_nxt = 1'b0;
          emit_j_nxt  = '0;
          state_nxt   = (cols == '0) ? S_EMIT : S_BUILD;
        end
      end

      // walk the index one bit a cycle to find its lowest set bit
      S_SCAN: begin
        emit_j_nxt = '0;
        if (scan_k_r == cols) begin
          state_nxt = S_EMIT;
        end else if (scan_sr_r[0]) begin
          bld_j_nxt   = '0;
          bld_m_nxt   = scan_k_r[COL_W-1:0];
          bld_lo_nxt  = scan_k_r[COL_W-1:0];
          bld_hi_nxt  = scan_k_r[COL_W-1:0];
          bld_all_nxt = 1'b1;
          state_nxt   = S_BUILD;
        end else begin
          scan_sr_nxt = scan_sr_r >> 1;
          scan_k_nxt  = scan_k_r + 6'd1;
        end
      end

      // issue one matrix read a cycle: dimension outer, column inner
      S_BUILD: begin
        if (bld_m_r == bld_hi_r) begin
          bld_m_nxt = bld_lo_r;
          bld_j_nxt = bld_j_r + DIM_W'(1);
          if (bld_j_r == DIM_W'(MAX_DIMS - 1)) begin
            state_nxt = S_DRAIN;
          end
        end else begin
          bld_m_nxt = bld_m_r + COL_W'(1);
        end
      end

      S_DRAIN: begin
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (nd == '0) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          load_pt = 1'b1;
          if (({1'b0, emit_j_r} + 5'd1) == nd) begin
            state_nxt = S_IDLE;
          end else begin
            emit_j_nxt = emit_j_r + DIM_W'(1);
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          load_err  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      first_r  <= '0;
      cur_r    <= '0;
      endidx_r <= '0;
      run_r    <= 1'b0;
      tag_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      first_r  <= first_nxt;
      cur_r    <= cur_nxt;
      endidx_r <= endidx_nxt;
      run_r    <= run_nxt;
      tag_v_r  <= (state_r == S_BUILD);
    end
  end

  always_ff @(posedge clk) begin
    start_r   <= start_nxt;
    end_r     <= end_nxt;
    g_r       <= g_nxt;
    scan_sr_r <= scan_sr_nxt;
    scan_k_r  <= scan_k_nxt;
    bld_j_r   <= bld_j_nxt;
    bld_m_r   <= bld_m_nxt;
    bld_lo_r  <= bld_lo_nxt;
    bld_hi_r  <= bld_hi_nxt;
    bld_all_r <= bld_all_nxt;
    emit_j_r  <= emit_j_nxt;
    err_r     <= err_nxt;
    tag_j_r   <= bld_j_r;
    tag_sel_r <= bld_all_r | g_r[bld_m_r];
  end

  dng_mat_mem u_mat (
    .clk   (clk),
    .we    (in_acc && (op_t'(in_ch.op) == OP_LOAD_MAT)),
    .waddr ({in_ch.dim, in_ch.column}),
    .wdata (in_ch.word),
    .raddr ({bld_j_r, bld_m_r}),
    .rdata (mem_rdata)
  );

  always_comb begin
    cctl.clear     = clear_acc;
    cctl.xor_en    = tag_v_r && tag_sel_r;
    cctl.rd_dim    = (state_r == S_EMIT) ? emit_j_r : tag_j_r;
    cctl.shift_we  = in_acc && (op_t'(in_ch.op) == OP_LOAD_SHIFT);
    cctl.shift_dim = in_ch.dim;
  end

  dng_coord u_coord (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (cctl),
    .shift_wdata  (in_ch.word),
    .xor_data     (mem_rdata),
    .fmask        (frac_mask(fraction_bits_r)),
    .shift_en     (shift_enable_r),
    .point_word   (point_word),
    .shifted_word (shifted_word)
  );

  // result register: hold a beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load_pt || load_err || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load_pt) begin
      out_status_r   <= ST_OK;
      out_position_r <= slot[31:0] - first_r;
      out_dim_r      <= emit_j_r;
      out_point_r    <= point_word;
      out_shifted_r  <= shifted_word;
      out_last_r     <= ({1'b0, emit_j_r} + 5'd1) == nd;
    end else if (load_err) begin
      out_status_r   <= err_r;
      out_position_r <= '0;
      out_dim_r      <= '0;
      out_point_r    <= '0;
      out_shifted_r  <= '0;
      out_last_r     <= 1'b1;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.position     = out_position_r;
  assign out_ch.out_dim      = out_dim_r;
  assign out_ch.point_word   = out_point_r;
  assign out_ch.shifted_word = out_shifted_r;
  assign out_ch.last         = out_last_r;

endmodule
